/* rtl/core/csms_pkg.sv */
// ----------------------------------------------------------------------------
// csms_pkg
// Shared types and constants of the charge session meter supervisor core.
// ----------------------------------------------------------------------------
`default_nettype none

package csms_pkg;

    localparam int unsigned EnergyW = 48;
    localparam int unsigned ValW    = 16;
    localparam int unsigned TempW   = 12;
    localparam int unsigned CountW  = 8;
    localparam int unsigned SumW    = 24;
    localparam int unsigned PowerW  = 32;
    localparam int unsigned CfgAddrW = 3;

    // register indexes of the configuration port
    localparam logic [CfgAddrW-1:0] REG_ENERGY_LIMIT = 3'd0;
    localparam logic [CfgAddrW-1:0] REG_LOW_VOLTAGE  = 3'd1;
    localparam logic [CfgAddrW-1:0] REG_HIGH_VOLTAGE = 3'd2;
    localparam logic [CfgAddrW-1:0] REG_HIGH_CURRENT = 3'd3;
    localparam logic [CfgAddrW-1:0] REG_LOW_CURRENT  = 3'd4;
    localparam logic [CfgAddrW-1:0] REG_HIGH_TEMP    = 3'd5;
    localparam logic [CfgAddrW-1:0] REG_AVG_COUNT    = 3'd6;

    // configuration reset values
    localparam logic [EnergyW-1:0] RST_ENERGY_LIMIT = '0;
    localparam logic [ValW-1:0]    RST_LOW_VOLTAGE  = 16'd18000;
    localparam logic [ValW-1:0]    RST_HIGH_VOLTAGE = 16'd26000;
    localparam logic [ValW-1:0]    RST_HIGH_CURRENT = 16'd16000;
    localparam logic [ValW-1:0]    RST_LOW_CURRENT  = 16'd100;
    localparam logic [TempW-1:0]   RST_HIGH_TEMP    = 12'd700;
    localparam logic [CountW-1:0]  RST_AVG_COUNT    = 8'd15;

    // held reading reset values
    localparam logic [ValW-1:0]  RST_HELD_VOLTAGE = 16'd23000;
    localparam logic [ValW-1:0]  RST_HELD_CURRENT = '0;
    localparam logic [TempW-1:0] RST_HELD_TEMP    = 12'd300;

    typedef struct packed {
        logic [EnergyW-1:0] energy_limit;
        logic [ValW-1:0]    low_voltage;
        logic [ValW-1:0]    high_voltage;
        logic [ValW-1:0]    high_current;
        logic [ValW-1:0]    low_current;
        logic [TempW-1:0]   high_temp;
        logic [CountW-1:0]  avg_count;
    } csms_cfg_t;

    // one metering tick as taken from the input channel
    typedef struct packed {
        logic             reading_valid;
        logic             session_active;
        logic [ValW-1:0]  voltage_cv;
        logic [ValW-1:0]  current_ma;
        logic [TempW-1:0] temperature_dc;
    } csms_tick_t;

    // one tick after the held readings are applied
    typedef struct packed {
        logic              session_active;
        logic              out_of_window;
        logic [PowerW-1:0] power;
        logic [ValW-1:0]   held_current;
    } csms_smp_t;

endpackage

`default_nettype wire

/* rtl/core/csms_cfg_regs.sv */
// ----------------------------------------------------------------------------
// csms_cfg_regs
// Configuration register bank, write only, indexed by register number.
// ----------------------------------------------------------------------------
`default_nettype none

module csms_cfg_regs (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               cfg_we,
    input  wire  [csms_pkg::CfgAddrW-1:0]     cfg_addr,
    input  wire  [csms_pkg::EnergyW-1:0]      cfg_wdata,
    output csms_pkg::csms_cfg_t               cfg
);

    csms_pkg::csms_cfg_t cfg_reg;
    csms_pkg::csms_cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_addr)
                csms_pkg::REG_ENERGY_LIMIT: cfg_next.energy_limit = cfg_wdata;
                csms_pkg::REG_LOW_VOLTAGE:
                    cfg_next.low_voltage = cfg_wdata[csms_pkg::ValW-1:0];
                csms_pkg::REG_HIGH_VOLTAGE:
                    cfg_next.high_voltage = cfg_wdata[csms_pkg::ValW-1:0];
                csms_pkg::REG_HIGH_CURRENT:
                    cfg_next.high_current = cfg_wdata[csms_pkg::ValW-1:0];
                csms_pkg::REG_LOW_CURRENT:
                    cfg_next.low_current = cfg_wdata[csms_pkg::ValW-1:0];
                csms_pkg::REG_HIGH_TEMP:
                    cfg_next.high_temp = cfg_wdata[csms_pkg::TempW-1:0];
                csms_pkg::REG_AVG_COUNT:
                    cfg_next.avg_count = cfg_wdata[csms_pkg::CountW-1:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.energy_limit <= csms_pkg::RST_ENERGY_LIMIT;
            cfg_reg.low_voltage  <= csms_pkg::RST_LOW_VOLTAGE;
            cfg_reg.high_voltage <= csms_pkg::RST_HIGH_VOLTAGE;
            cfg_reg.high_current <= csms_pkg::RST_HIGH_CURRENT;
            cfg_reg.low_current  <= csms_pkg::RST_LOW_CURRENT;
            cfg_reg.high_temp    <= csms_pkg::RST_HIGH_TEMP;
            cfg_reg.avg_count    <= csms_pkg::RST_AVG_COUNT;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

/* rtl/core/csms_sample_stage.sv */
// ----------------------------------------------------------------------------
// csms_sample_stage
// Input register, held reading update, power product and window checks.
// ----------------------------------------------------------------------------
`default_nettype none

module csms_sample_stage (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  csms_pkg::csms_cfg_t          cfg,
    input  wire                          s_tvalid,
    output logic                         s_tready,
    input  wire  [47:0]                  s_tdata,
    input  wire  [1:0]                   s_tuser,
    output logic                         smp_valid,
    input  wire                          smp_ready,
    output csms_pkg::csms_smp_t          smp_item
);

    logic                    in_valid_reg;
    csms_pkg::csms_tick_t    in_item_reg;
    csms_pkg::csms_tick_t    in_item_next;
    logic                    in_ready;
    logic                    in_fire;

    logic                    smp_valid_reg;
    csms_pkg::csms_smp_t     smp_item_reg;
    csms_pkg::csms_smp_t     smp_item_next;
    logic                    smp_load;

    logic [csms_pkg::ValW-1:0]  held_voltage_reg, held_voltage_next;
    logic [csms_pkg::ValW-1:0]  held_current_reg, held_current_next;
    logic [csms_pkg::TempW-1:0] held_temp_reg, held_temp_next;
    logic                       over_range;

    // input register
    always_comb begin
        in_item_next.reading_valid  = s_tuser[0];
        in_item_next.session_active = s_tuser[1];
        in_item_next.voltage_cv     = s_tdata[15:0];
        in_item_next.current_ma     = s_tdata[31:16];
        in_item_next.temperature_dc = s_tdata[43:32];
    end

    assign smp_load = in_valid_reg && (!smp_valid_reg || smp_ready);
    assign in_ready = !in_valid_reg || smp_load;
    assign in_fire  = s_tvalid && in_ready;
    assign s_tready = in_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_ready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            in_item_reg <= in_item_next;
        end
    end

    // held readings as seen by this tick
    always_comb begin
        held_voltage_next = held_voltage_reg;
        held_current_next = held_current_reg;
        held_temp_next    = held_temp_reg;
        if (in_item_reg.reading_valid) begin
            held_voltage_next = in_item_reg.voltage_cv;
            held_current_next = (in_item_reg.current_ma < cfg.low_current) ?
                                '0 : in_item_reg.current_ma;
            held_temp_next    = in_item_reg.temperature_dc;
        end
    end

    always_comb begin
        over_range = (held_voltage_next > cfg.high_voltage) ||
                     (held_voltage_next < cfg.low_voltage) ||
                     (held_current_next > cfg.high_current) ||
                     ($signed(held_temp_next) > $signed(cfg.high_temp));
        smp_item_next.session_active = in_item_reg.session_active;
        smp_item_next.out_of_window  = over_range;
        smp_item_next.power          = csms_pkg::PowerW'(held_voltage_next) *
                                       csms_pkg::PowerW'(held_current_next);
        smp_item_next.held_current   = held_current_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_voltage_reg <= csms_pkg::RST_HELD_VOLTAGE;
            held_current_reg <= csms_pkg::RST_HELD_CURRENT;
            held_temp_reg    <= csms_pkg::RST_HELD_TEMP;
            smp_valid_reg    <= 1'b0;
        end else begin
            if (smp_load) begin
                held_voltage_reg <= held_voltage_next;
                held_current_reg <= held_current_next;
                held_temp_reg    <= held_temp_next;
            end
            if (!smp_valid_reg || smp_ready) begin
                smp_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (smp_load) begin
            smp_item_reg <= smp_item_next;
        end
    end

    assign smp_valid = smp_valid_reg;
    assign smp_item  = smp_item_reg;

endmodule

`default_nettype wire

/* rtl/core/csms_accum_stage.sv */
// ----------------------------------------------------------------------------
// csms_accum_stage
// Session accumulation, current averaging, flag latches and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module csms_accum_stage (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  csms_pkg::csms_cfg_t          cfg,
    input  wire                          smp_valid,
    output logic                         smp_ready,
    input  csms_pkg::csms_smp_t          smp_item,
    output logic                         m_tvalid,
    input  wire                          m_tready,
    output logic [79:0]                  m_tdata,
    output logic [3:0]                   m_tuser
);

    logic                             fire;
    logic                             acc;
    logic [csms_pkg::EnergyW:0]       energy_sum;
    logic [csms_pkg::EnergyW-1:0]     energy_sat;
    logic                             limit_hit;
    logic [csms_pkg::SumW-1:0]        sum_add;
    logic [csms_pkg::CountW-1:0]      count_add;
    logic [csms_pkg::CountW-1:0]      win_size;
    logic                             win_close;
    logic [csms_pkg::SumW:0]          floor_total;
    logic                             low_avg;

    logic [csms_pkg::EnergyW-1:0]     energy_reg, energy_next;
    logic [csms_pkg::SumW-1:0]        cur_sum_reg, cur_sum_next;
    logic [csms_pkg::CountW-1:0]      win_count_reg, win_count_next;
    logic [csms_pkg::SumW-1:0]        floor_reg, floor_next;
    logic                             overload_reg, overload_next;
    logic                             full_reg, full_next;
    logic                             timeout_reg, timeout_next;

    logic                             m_valid_reg;
    logic [79:0]                      m_data_reg;
    logic [3:0]                       m_user_reg;

    assign smp_ready = !m_valid_reg || m_tready;
    assign fire      = smp_valid && smp_ready;
    assign acc       = smp_item.session_active && !overload_reg && !full_reg && !timeout_reg;

    always_comb begin
        energy_sum = {1'b0, energy_reg} +
                     (csms_pkg::EnergyW + 1)'(smp_item.power);
        energy_sat = energy_sum[csms_pkg::EnergyW] ? '1 :
                     energy_sum[csms_pkg::EnergyW-1:0];
        limit_hit  = (cfg.energy_limit != '0) && (energy_sat >= cfg.energy_limit);

        sum_add     = cur_sum_reg + csms_pkg::SumW'(smp_item.held_current);
        count_add   = win_count_reg + 1'b1;
        win_size    = (cfg.avg_count == '0) ? csms_pkg::CountW'(1) : cfg.avg_count;
        win_close   = count_add >= win_size;
        // floor_reg tracks low_current times the samples already in the window
        floor_total = {1'b0, floor_reg} + (csms_pkg::SumW + 1)'(cfg.low_current);
        low_avg     = win_close && ({1'b0, sum_add} < floor_total);
    end

    always_comb begin
        energy_next    = energy_reg;
        cur_sum_next   = cur_sum_reg;
        win_count_next = win_count_reg;
        floor_next     = csms_pkg::SumW'(cfg.low_current) * csms_pkg::SumW'(win_count_reg);
        overload_next  = overload_reg;
        full_next      = full_reg;
        timeout_next   = timeout_reg;
        if (fire) begin
            floor_next = floor_reg;
            if (acc) begin
                energy_next    = limit_hit ? '0 : energy_sat;
                cur_sum_next   = win_close ? '0 : sum_add;
                win_count_next = win_close ? '0 : count_add;
                floor_next     = win_close ? '0 : floor_total[csms_pkg::SumW-1:0];
                overload_next  = overload_reg || smp_item.out_of_window;
                full_next      = full_reg || low_avg;
                timeout_next   = timeout_reg || limit_hit;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            energy_reg    <= '0;
            cur_sum_reg   <= '0;
            win_count_reg <= '0;
            floor_reg     <= '0;
            overload_reg  <= 1'b0;
            full_reg      <= 1'b0;
            timeout_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            energy_reg    <= energy_next;
            cur_sum_reg   <= cur_sum_next;
            win_count_reg <= win_count_next;
            floor_reg     <= floor_next;
            overload_reg  <= overload_next;
            full_reg      <= full_next;
            timeout_reg   <= timeout_next;
            if (smp_ready) begin
                m_valid_reg <= smp_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            m_data_reg <= {energy_next, smp_item.power};
            m_user_reg <= {acc, timeout_next, full_next, overload_next};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

`default_nettype wire

/* rtl/core/charge_session_meter_supervisor_core.sv */
// path: an input transfer passes the input, sample and result registers before m_tvalid
// throughput: one tick per cycle while m_tready allows, set by the held reading and accumulator registers
// ready propagates back combinationally through three registered stages, so bubbles are absorbed
// reset: synchronous, aresetn low clears flags and totals and reloads held readings
// configuration returns to its default values at reset
// ----------------------------------------------------------------------------
// charge_session_meter_supervisor_core
// Metering tick supervisor: power, session energy, averaged current and
// latched overload, battery full and session timeout flags.
// ----------------------------------------------------------------------------
`default_nettype none

module charge_session_meter_supervisor_core (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  wire                           cfg_we,
    input  wire  [csms_pkg::CfgAddrW-1:0] cfg_addr,
    input  wire  [csms_pkg::EnergyW-1:0]  cfg_wdata,
    input  wire                           s_tvalid,
    output logic                          s_tready,
    // voltage_cv[15:0], current_ma[31:16], temperature_dc[43:32], zero pad
    input  wire  [47:0]                   s_tdata,
    // reading_valid[0], session_active[1]
    input  wire  [1:0]                    s_tuser,
    output logic                          m_tvalid,
    input  wire                           m_tready,
    // power_now[31:0], energy_total[79:32]
    output logic [79:0]                   m_tdata,
    // overload[0], battery_full[1], session_timeout[2], accumulated[3]
    output logic [3:0]                    m_tuser
);

    csms_pkg::csms_cfg_t cfg;
    csms_pkg::csms_smp_t smp_item;
    logic                smp_valid;
    logic                smp_ready;

    csms_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    csms_sample_stage u_sample (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .smp_valid (smp_valid),
        .smp_ready (smp_ready),
        .smp_item  (smp_item)
    );

    csms_accum_stage u_accum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .smp_valid (smp_valid),
        .smp_ready (smp_ready),
        .smp_item  (smp_item),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire
